@@ sv/l2lpp_pkg.sv @@
// Package for the linear-to-log pixel packer: widths, lane types and the
// log threshold table, which is built at elaboration by integer functions.
// Used by l2lpp_cell, the core and the checker; depends on nothing else.
package l2lpp_pkg;

	// Code and fixed-point widths.
	localparam int CODE_BITS = 10;
	localparam int FRAC_BITS = 20;
	localparam int IN_W      = 28;
	localparam int THR_W     = IN_W + 4;
	localparam int NCH       = 3;
	localparam int WORD_W    = 32;
	localparam int ENTRIES   = 1 << CODE_BITS;

	// Configuration port geometry.
	localparam int PADDR_W   = 3;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_ENABLE = '0;
	localparam logic [NCH-1:0] CHAN_EN_RESET = '1;

	// Cineon curve constants.
	localparam longint REF_WHITE   = 685;
	localparam longint REF_BLACK   = 95;
	localparam longint STEP_DIV    = 300;
	localparam longint LOG2_10_Q32 = 64'sd14267572527;
	localparam longint unsigned LN2_Q30 = 64'd744261118;

	// Bits below the lowest channel field stay zero.
	localparam int BLUE_SHIFT = WORD_W - NCH * CODE_BITS;
	localparam logic [WORD_W-1:0] PAD_MASK =
		(BLUE_SHIFT > 0) ? WORD_W'((64'd1 << BLUE_SHIFT) - 64'd1) : '0;

	typedef logic signed [IN_W-1:0]  lin_t;
	typedef logic [CODE_BITS-1:0]    code_t;
	typedef logic signed [THR_W-1:0] thr_t;
	typedef thr_t thr_table_t [ENTRIES];

	// The search starts at the top code bit.
	localparam code_t PROBE_INIT = code_t'(1) << (CODE_BITS - 1);

	// Data that travels along the cell chain.
	typedef struct packed {
		lin_t [NCH-1:0]  value;
		code_t [NCH-1:0] code;
		code_t           probe;
	} lane_t;

	// Shift-subtract division, used only while the table is built.
	function automatic longint unsigned udiv(longint unsigned a, longint unsigned b);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) begin
				r = r - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Floor division for a positive divisor.
	function automatic longint floor_div(longint a, longint b);
		longint unsigned mag;
		if (a >= 0) begin
			return longint'(udiv(longint'(a), longint'(b)));
		end
		mag = longint'(-a) + longint'(b) - 1;
		return -longint'(udiv(mag, longint'(b)));
	endfunction

	// Ten to the power n/d in Q32, from a truncated exponential series.
	function automatic longint pow10_q32(longint n, longint d);
		longint y;
		longint k;
		longint sh;
		longint unsigned f;
		longint unsigned x;
		longint unsigned term;
		longint unsigned sum;
		y = floor_div(n * LOG2_10_Q32, d);
		k = y >>> 32;
		f = longint'(y - (k <<< 32));
		x = (f * LN2_Q30) >> 32;
		term = 64'd1 << 30;
		sum = term;
		for (int j = 1; j <= 12; j++) begin
			term = udiv((term * x) >> 30, longint'(j));
			sum = sum + term;
		end
		sh = 2 + k;
		if (sh >= 0) begin
			if (sh > 30) begin
				sh = 30;
			end
			return longint'(sum << sh);
		end
		if (-sh > 62) begin
			return 0;
		end
		return longint'(sum >> (-sh));
	endfunction

	// One threshold for each code, rising with the code.
	function automatic thr_table_t build_table();
		thr_table_t tbl;
		longint bq;
		longint den;
		longint n;
		longint p;
		longint num;
		longint scale;
		scale = longint'(ENTRIES);
		bq = pow10_q32(REF_BLACK - REF_WHITE, STEP_DIV);
		den = (64'sd1 <<< 32) - bq;
		for (int i = 0; i < ENTRIES; i++) begin
			n = longint'(2 * i + 1) * 512 - REF_WHITE * scale;
			p = pow10_q32(n, STEP_DIV * scale);
			num = (p - bq) * (64'sd1 <<< FRAC_BITS);
			tbl[i] = THR_W'(floor_div(2 * num + den, 2 * den));
		end
		return tbl;
	endfunction

	localparam thr_table_t THR_TABLE = build_table();

	// Places the three codes in the word, red highest; disabled channels stay zero.
	function automatic logic [WORD_W-1:0] pack_word(code_t [NCH-1:0] code,
			logic [NCH-1:0] en);
		logic [WORD_W-1:0] w;
		int sh;
		w = '0;
		for (int c = 0; c < NCH; c++) begin
			sh = WORD_W - (c + 1) * CODE_BITS;
			if (en[NCH-1-c]) begin
				if (sh >= 0) begin
					w = w | (WORD_W'(code[c]) << sh);
				end else begin
					w = w | (WORD_W'(code[c]) >> (-sh));
				end
			end
		end
		return w;
	endfunction

endpackage

@@ sv/l2lpp_cell.sv @@
// One cell of the threshold search chain: it settles one code bit for all
// three channels in two stages. Depends on l2lpp_pkg for types and the table.
module l2lpp_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              valid_in,
	input  l2lpp_pkg::lane_t  lane_in,
	output logic              valid_out,
	output l2lpp_pkg::lane_t  lane_out
);
	import l2lpp_pkg::*;

	logic            valid_s1;
	logic            valid_s2;
	lane_t           lane_s1;
	lane_t           lane_s2;
	thr_t [NCH-1:0]  thr_s1;
	code_t [NCH-1:0] idx;

	// The threshold just below the candidate code decides the probe bit.
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			idx[ch] = (lane_in.code[ch] | lane_in.probe) - code_t'(1);
		end
	end

	// Valid flags of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	// First stage: registered table read.
	always_ff @(posedge clk) begin
		if (adv) begin
			lane_s1 <= lane_in;
			for (int ch = 0; ch < NCH; ch++) begin
				thr_s1[ch] <= THR_TABLE[idx[ch]];
			end
		end
	end

	// Second stage: keep the probe bit where the threshold lies below the value.
	always_ff @(posedge clk) begin
		if (adv) begin
			lane_s2.value <= lane_s1.value;
			lane_s2.probe <= lane_s1.probe >> 1;
			for (int ch = 0; ch < NCH; ch++) begin
				if (thr_s1[ch] < thr_t'($signed(lane_s1.value[ch]))) begin
					lane_s2.code[ch] <= lane_s1.code[ch] | lane_s1.probe;
				end else begin
					lane_s2.code[ch] <= lane_s1.code[ch];
				end
			end
		end
	end

	assign valid_out = valid_s2;
	assign lane_out  = lane_s2;

endmodule

@@ sv/linear_to_log10_pixel_packer_core.sv @@
// Linear-to-log pixel packer: a chain of CODE_BITS search cells and an output word register.
// One pixel per cycle is taken while the output word register is empty or its word is taken.
// Each cell does one registered table read and one compare; a stalled word holds the chain.
// Reset clears the valid flags and sets channel_enable to all channels on; the threshold
// table is constant and needs no fill. Depends on l2lpp_pkg and l2lpp_cell.
module linear_to_log10_pixel_packer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [l2lpp_pkg::PADDR_W-1:0]       paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                pixel_valid,
	output logic                                pixel_ready,
	input  l2lpp_pkg::lin_t                     red_linear,
	input  l2lpp_pkg::lin_t                     green_linear,
	input  l2lpp_pkg::lin_t                     blue_linear,
	output logic                                word_valid,
	input  logic                                word_ready,
	output logic [l2lpp_pkg::WORD_W-1:0]        packed_word
);
	import l2lpp_pkg::*;

	logic [NCH-1:0]       chan_en_q;
	logic                 word_valid_q;
	logic [WORD_W-1:0]    word_q;
	logic                 adv;
	logic [REG_IDX_W-1:0] reg_idx;
	logic [CODE_BITS:0]   chain_valid;
	lane_t                chain_lane [CODE_BITS+1];

	// The whole chain moves whenever the output register can take a word.
	assign adv         = !word_valid_q || word_ready;
	assign pixel_ready = adv;

	// Configuration register.
	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_CHANNEL_ENABLE) ? 32'(chan_en_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_en_q <= CHAN_EN_RESET;
		end else if (psel && penable && pwrite && (reg_idx == REG_CHANNEL_ENABLE)) begin
			chan_en_q <= pwdata[NCH-1:0];
		end
	end

	// Head of the chain: the new pixel with all codes zero.
	always_comb begin
		chain_lane[0].value[0] = red_linear;
		chain_lane[0].value[1] = green_linear;
		chain_lane[0].value[2] = blue_linear;
		chain_lane[0].code     = '0;
		chain_lane[0].probe    = PROBE_INIT;
	end
	assign chain_valid[0] = pixel_valid;

	// One cell per code bit, top bit first.
	for (genvar g = 0; g < CODE_BITS; g++) begin : g_cell
		l2lpp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.valid_in  (chain_valid[g]),
			.lane_in   (chain_lane[g]),
			.valid_out (chain_valid[g+1]),
			.lane_out  (chain_lane[g+1])
		);
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= 1'b0;
		end else if (adv) begin
			word_valid_q <= chain_valid[CODE_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_q <= pack_word(chain_lane[CODE_BITS].code, chan_en_q);
		end
	end

	assign word_valid  = word_valid_q;
	assign packed_word = word_q;

endmodule

@@ sv/l2lpp_checker.sv @@
// Port-level checks for the linear-to-log pixel packer, bound to the core.
// Depends on l2lpp_pkg for widths and the pad mask.
module l2lpp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pixel_ready,
	input logic                          word_valid,
	input logic                          word_ready,
	input logic [l2lpp_pkg::WORD_W-1:0]  packed_word
);
	import l2lpp_pkg::*;

	// A word that is not taken stays on the port unchanged.
	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && !word_ready |=> word_valid && $stable(packed_word))
		else $error("stalled word changed or dropped");

	// A pixel is taken exactly when the output side can move.
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_ready == (!word_valid || word_ready))
		else $error("pixel_ready does not follow the output register");

	// A new word can only appear after the chain advanced.
	a_word_needs_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(word_valid) |-> $past(pixel_ready))
		else $error("word appeared while the chain was stalled");

	// The pad bits below the blue field are always zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid |-> ((packed_word & PAD_MASK) == '0))
		else $error("pad bits of the word are not zero");

endmodule

bind linear_to_log10_pixel_packer_core l2lpp_checker u_l2lpp_checker (.*);
